// ----- rtl/trsts_pkg.sv -----
// Shared types, constants and helpers for the task ring and soft timer scheduler.
// No dependencies; every other file in rtl/ imports this package.
package trsts_pkg;

  localparam int QUEUE_DEPTH = 64;
  localparam int TIMER_SLOTS = 16;
  localparam int TASK_BITS   = 8;

  localparam int IDX_W   = $clog2(QUEUE_DEPTH);
  localparam int LEN_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int SLOT_W  = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
  localparam int AGE_W   = SLOT_W;
  localparam int ENTRY_W = TASK_BITS + 1;
  localparam int CFG_W   = 7;
  localparam logic [CFG_W-1:0] LEN_RESET = CFG_W'(16);

  typedef enum logic [2:0] {
    OP_STEP    = 3'd0,
    OP_POST    = 3'd1,
    OP_ADD     = 3'd2,
    OP_DEL     = 3'd3,
    OP_DEL_ALL = 3'd4,
    OP_STOP    = 3'd5
  } op_e;

  typedef enum logic [2:0] {
    K_IDLE     = 3'd0,
    K_DISPATCH = 3'd1,
    K_STOP     = 3'd2,
    K_ACCEPT   = 3'd3,
    K_CREATED  = 3'd4,
    K_REJECT   = 3'd5
  } kind_e;

  typedef enum logic [2:0] {
    C_NONE,
    C_ADD,
    C_REMOVE,
    C_ADVANCE,
    C_CLEAR
  } cell_op_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_DEQ,
    S_READ,
    S_RESP
  } state_e;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [31:0] now_ms;
    logic [7:0]  task_id;
    logic [31:0] interval;
    logic        periodic;
    logic [3:0]  timer_slot;
  } in_word_t;

  typedef struct packed {
    logic [2:0] result_kind;
    logic [7:0] task_out;
    logic [3:0] slot_out;
    logic       fault;
  } out_word_t;

  // Command broadcast to every timer cell
  typedef struct packed {
    cell_op_e             op;
    logic [31:0]          now;
    logic [SLOT_W-1:0]    slot;
    logic [AGE_W-1:0]     age;
    logic [31:0]          interval;
    logic [TASK_BITS-1:0] task_id;
    logic                 rep;
  } cell_cmd_t;

  // Status returned by each timer cell
  typedef struct packed {
    logic                 valid;
    logic [AGE_W-1:0]     age;
    logic                 due;
    logic                 pick;
    logic [TASK_BITS-1:0] task_id;
    logic                 rep;
  } cell_stat_t;

  // Ring length in use, clamped to [2, QUEUE_DEPTH]
  function automatic logic [LEN_W-1:0] eff_len(input logic [CFG_W-1:0] q);
    logic [LEN_W-1:0] n;
    if (q < CFG_W'(2)) n = LEN_W'(2);
    else if (int'(q) > QUEUE_DEPTH) n = LEN_W'(QUEUE_DEPTH);
    else n = LEN_W'(q);
    return n;
  endfunction

  // Next ring index, wrapping at the length in use
  function automatic logic [IDX_W-1:0] adv(input logic [IDX_W-1:0] idx,
                                           input logic [LEN_W-1:0] len);
    logic [LEN_W-1:0] n;
    logic [IDX_W-1:0] r;
    n = LEN_W'(idx) + LEN_W'(1);
    if (n >= len) r = '0;
    else r = n[IDX_W-1:0];
    return r;
  endfunction

endpackage

// ----- rtl/trsts_task_ring.sv -----
// Task ring storage: one write port, one registered read port.
// Depends on trsts_pkg.
module trsts_task_ring (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [trsts_pkg::IDX_W-1:0]   waddr_i,
  input  logic [trsts_pkg::ENTRY_W-1:0] wdata_i,
  input  logic                        re_i,
  input  logic [trsts_pkg::IDX_W-1:0]   raddr_i,
  output logic [trsts_pkg::ENTRY_W-1:0] rdata_o
);
  import trsts_pkg::*;

  logic [ENTRY_W-1:0] mem [QUEUE_DEPTH];
  logic [ENTRY_W-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/trsts_timer_cell.sv -----
// One software timer slot: valid bit, age rank, start, interval, task, repeat.
// Depends on trsts_pkg; cells chain through the free-slot search.
module trsts_timer_cell (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [trsts_pkg::SLOT_W-1:0] idx_i,
  input  trsts_pkg::cell_cmd_t      cmd_i,
  input  logic                      free_i,
  output logic                      free_o,
  output trsts_pkg::cell_stat_t     stat_o
);
  import trsts_pkg::*;

  logic                 valid_q;
  logic [AGE_W-1:0]     age_q;
  logic [31:0]          start_q;
  logic [31:0]          ivl_q;
  logic [TASK_BITS-1:0] task_q;
  logic                 rep_q;
  logic                 pick;
  logic                 me;
  logic [31:0]          elapsed;

  // lowest free slot: first empty cell with no empty cell below it
  assign pick   = !valid_q && !free_i;
  assign free_o = free_i || !valid_q;
  assign me     = (cmd_i.slot == idx_i);

  assign elapsed = cmd_i.now - start_q;

  always_comb begin
    stat_o         = '0;
    stat_o.valid   = valid_q;
    stat_o.age     = age_q;
    stat_o.due     = (elapsed >= ivl_q);
    stat_o.pick    = pick;
    stat_o.task_id = task_q;
    stat_o.rep     = rep_q;
  end

  // valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      unique case (cmd_i.op)
        C_ADD:    if (pick) valid_q <= 1'b1;
        C_REMOVE: if (me) valid_q <= 1'b0;
        C_CLEAR:  valid_q <= 1'b0;
        default: ;
      endcase
    end
  end

  // timer payload and age rank
  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      C_ADD: begin
        if (pick) begin
          age_q   <= '0;
          start_q <= cmd_i.now;
          ivl_q   <= cmd_i.interval;
          task_q  <= cmd_i.task_id;
          rep_q   <= cmd_i.rep;
        end else if (valid_q) begin
          age_q <= age_q + AGE_W'(1);
        end
      end
      C_REMOVE: begin
        if (valid_q && !me && (age_q > cmd_i.age)) age_q <= age_q - AGE_W'(1);
      end
      C_ADVANCE: begin
        if (me) start_q <= start_q + ivl_q;
      end
      default: ;
    endcase
  end

endmodule

// ----- rtl/task_ring_and_soft_timer_scheduler.sv -----
// Cooperative task queue with a row of software timer cells. Each word is
// one command; each produces exactly one result word. Post, stop, add,
// delete and delete-all pass from execute straight to the result; a step
// with queued work dequeues and reads the ring first; a step on an empty
// queue first scans the live timers and then reports idle, or dispatches
// a fired timer's task, the scan walking the timers newest first, one age
// rank per cycle, across the cell row. The next word is taken once the
// result has moved into the output register. Configuration writes land at once.
// Depends on trsts_pkg, trsts_task_ring, trsts_timer_cell.
module task_ring_and_soft_timer_scheduler (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  trsts_pkg::in_word_t          in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output trsts_pkg::out_word_t         out_data_o,
  input  logic                         cfg_we_i,
  input  logic [trsts_pkg::CFG_W-1:0]  cfg_data_i
);
  import trsts_pkg::*;

  state_e             state_q, state_d;
  in_word_t           cmd_q;
  logic [IDX_W-1:0]   rd_q, rd_d;
  logic [IDX_W-1:0]   wr_q;
  logic [CFG_W-1:0]   len_q;
  logic               fault_q;
  logic [AGE_W:0]     scan_q, scan_d;
  out_word_t          res_q, res_d;
  out_word_t          out_q;
  logic               out_valid_q;
  logic               out_load;

  logic [LEN_W-1:0]   len;
  logic               enq_req;
  logic [ENTRY_W-1:0] enq_entry;
  logic [IDX_W-1:0]   wr_nx;
  logic               enq_ok;
  logic               ring_re;
  logic [ENTRY_W-1:0] ring_rdata;

  cell_cmd_t          ccmd;
  cell_stat_t         st [TIMER_SLOTS];
  logic               free_c [TIMER_SLOTS+1];

  logic                 hit_any, hit_due, hit_rep;
  logic [SLOT_W-1:0]    hit_slot, pick_slot, sel;
  logic [TASK_BITS-1:0] hit_task;
  logic                 sel_ok;

  assign len     = eff_len(len_q);
  assign wr_nx   = adv(wr_q, len);
  assign enq_ok  = enq_req && (wr_nx != rd_q);
  assign sel     = SLOT_W'(cmd_q.timer_slot);
  assign sel_ok  = (int'(cmd_q.timer_slot) < TIMER_SLOTS) && st[sel].valid;

  trsts_task_ring u_ring (
    .clk_i   (clk_i),
    .we_i    (enq_ok),
    .waddr_i (wr_nx),
    .wdata_i (enq_entry),
    .re_i    (ring_re),
    .raddr_i (rd_d),
    .rdata_o (ring_rdata)
  );

  // timer cell row
  assign free_c[0] = 1'b0;
  for (genvar g = 0; g < TIMER_SLOTS; g++) begin : g_cell
    trsts_timer_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .idx_i  (SLOT_W'(g)),
      .cmd_i  (ccmd),
      .free_i (free_c[g]),
      .free_o (free_c[g+1]),
      .stat_o (st[g])
    );
  end

  // gather the scan hit and the free slot from the row
  always_comb begin
    logic h;
    hit_any   = 1'b0;
    hit_due   = 1'b0;
    hit_rep   = 1'b0;
    hit_slot  = '0;
    hit_task  = '0;
    pick_slot = '0;
    for (int i = 0; i < TIMER_SLOTS; i++) begin
      h = st[i].valid && !scan_q[AGE_W] && (st[i].age == scan_q[AGE_W-1:0]);
      hit_any  = hit_any | h;
      hit_due  = hit_due | (h & st[i].due);
      hit_rep  = hit_rep | (h & st[i].rep);
      hit_slot = hit_slot | (h ? SLOT_W'(i) : '0);
      hit_task = hit_task | (h ? st[i].task_id : '0);
      pick_slot = pick_slot | (st[i].pick ? SLOT_W'(i) : '0);
    end
  end

  // next state and command sequencing
  always_comb begin
    state_d   = state_q;
    rd_d      = rd_q;
    scan_d    = scan_q;
    res_d     = res_q;
    enq_req   = 1'b0;
    enq_entry = '0;
    ring_re   = 1'b0;
    out_load  = 1'b0;
    ccmd          = '0;
    ccmd.op       = C_NONE;
    ccmd.now      = cmd_q.now_ms;
    ccmd.interval = cmd_q.interval;
    ccmd.task_id  = TASK_BITS'(cmd_q.task_id);
    ccmd.rep      = cmd_q.periodic;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_EXEC;
      end
      S_EXEC: begin
        res_d   = '0;
        state_d = S_RESP;
        unique case (cmd_q.opcode)
          OP_STEP: begin
            if (rd_q == wr_q) begin
              scan_d  = '0;
              state_d = S_SCAN;
            end else begin
              state_d = S_DEQ;
            end
          end
          OP_POST, OP_STOP: begin
            enq_req = 1'b1;
            enq_entry = (cmd_q.opcode == OP_STOP) ? {1'b1, {TASK_BITS{1'b0}}}
                                                  : {1'b0, TASK_BITS'(cmd_q.task_id)};
            res_d.result_kind = enq_ok ? K_ACCEPT : K_REJECT;
          end
          OP_ADD: begin
            if (free_c[TIMER_SLOTS]) begin
              ccmd.op = C_ADD;
              res_d.result_kind = K_CREATED;
              res_d.slot_out    = 4'(pick_slot);
            end else begin
              res_d.result_kind = K_REJECT;
            end
          end
          OP_DEL: begin
            if (sel_ok) begin
              ccmd.op   = C_REMOVE;
              ccmd.slot = sel;
              ccmd.age  = st[sel].age;
              res_d.result_kind = K_ACCEPT;
            end else begin
              res_d.result_kind = K_REJECT;
            end
          end
          OP_DEL_ALL: begin
            ccmd.op = C_CLEAR;
            res_d.result_kind = K_ACCEPT;
          end
          default: res_d.result_kind = K_REJECT;
        endcase
      end
      S_SCAN: begin
        // one age rank per cycle, newest first
        if (hit_any) begin
          if (hit_due) begin
            enq_req   = 1'b1;
            enq_entry = {1'b0, hit_task};
            ccmd.slot = hit_slot;
            ccmd.age  = scan_q[AGE_W-1:0];
            if (hit_rep) begin
              ccmd.op = C_ADVANCE;
              scan_d  = scan_q + (AGE_W+1)'(1);
            end else begin
              ccmd.op = C_REMOVE;
            end
          end else begin
            scan_d = scan_q + (AGE_W+1)'(1);
          end
        end else if (rd_q == wr_q) begin
          res_d.result_kind = K_IDLE;
          state_d = S_RESP;
        end else begin
          state_d = S_DEQ;
        end
      end
      S_DEQ: begin
        rd_d    = adv(rd_q, len);
        ring_re = 1'b1;
        state_d = S_READ;
      end
      S_READ: begin
        if (ring_rdata[TASK_BITS]) begin
          res_d.result_kind = K_STOP;
        end else begin
          res_d.result_kind = K_DISPATCH;
          res_d.task_out    = 8'(ring_rdata[TASK_BITS-1:0]);
        end
        state_d = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rd_q        <= '0;
      wr_q        <= '0;
      len_q       <= LEN_RESET;
      fault_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      rd_q    <= rd_d;
      if (cfg_we_i) len_q <= cfg_data_i;
      if (enq_req) begin
        if (enq_ok) wr_q <= wr_nx;
        else fault_q <= 1'b1;
      end
      if (out_load) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i) cmd_q <= in_data_i;
    scan_q <= scan_d;
    res_q  <= res_d;
    if (out_load) begin
      out_q <= {res_q.result_kind, res_q.task_out, res_q.slot_out, fault_q};
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ----- rtl/trsts_checker.sv -----
// Port-level checks for the scheduler, attached to the top level by bind.
// Depends on trsts_pkg and task_ring_and_soft_timer_scheduler.
module trsts_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input trsts_pkg::out_word_t        out_data_o
);
  import trsts_pkg::*;

  logic seen_fault_q;

  // remember that a fault was reported
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) seen_fault_q <= 1'b0;
    else if (out_valid_o && out_data_o.fault) seen_fault_q <= 1'b1;
  end

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result word changed while stalled");

  // result kinds stay within the defined codes
  a_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.result_kind <= K_REJECT))
    else $error("undefined result kind");

  // the overflow fault never clears
  a_fault_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && seen_fault_q |-> out_data_o.fault)
    else $error("fault flag cleared");

  // task field only carries data on a dispatch
  a_task_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.result_kind != K_DISPATCH) |-> out_data_o.task_out == '0)
    else $error("task field set on a non-dispatch word");

  // slot field only carries data on a timer creation
  a_slot_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.result_kind != K_CREATED) |-> out_data_o.slot_out == '0)
    else $error("slot field set on a word that creates no timer");

endmodule

bind task_ring_and_soft_timer_scheduler trsts_checker u_trsts_checker (.*);

// ----- dv/tb_task_ring_and_soft_timer_scheduler.sv -----
// Self-checking testbench for the task ring and soft timer scheduler.
// Predicts every result word in-line from its own copy of the ring and timer
// table; depends on trsts_pkg and the task_ring_and_soft_timer_scheduler RTL.
`timescale 1ns / 1ps

module tb_task_ring_and_soft_timer_scheduler;
  import trsts_pkg::*;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_ready_o;
  in_word_t            in_data_i;
  logic                out_valid_o;
  logic                out_ready_i;
  out_word_t           out_data_o;
  logic                cfg_we_i;
  logic [CFG_W-1:0]    cfg_data_i;

  task_ring_and_soft_timer_scheduler i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i)
  );

  localparam logic [2:0] OP_BAD6 = 3'd6;
  localparam logic [2:0] OP_BAD7 = 3'd7;
  localparam logic [31:0] NEVER_MS = 32'hFFFF_FFFF;

  // Command words waiting for the driver, result words still owed by the DUT
  in_word_t  cmd_q[$];
  out_word_t owed_q[$];
  int        mismatches;
  bit        idle_on;
  bit        in_fire, out_fire, drv_on;
  int        in_gap, out_stall;

  // Scheduler shadow state
  logic [CFG_W-1:0] len_cfg;
  logic [8:0]       ring_mem [QUEUE_DEPTH];
  int               rd_idx, wr_idx;
  bit               fault_mdl;
  bit               tmr_live [TIMER_SLOTS];
  logic [31:0]      tmr_start [TIMER_SLOTS];
  logic [31:0]      tmr_ivl [TIMER_SLOTS];
  logic [7:0]       tmr_task [TIMER_SLOTS];
  bit               tmr_rep [TIMER_SLOTS];
  int               tmr_age [TIMER_SLOTS];
  logic [31:0]      sim_ms;

  function automatic int ring_len();
    int n;
    n = int'(len_cfg);
    if (n < 2) n = 2;
    if (n > QUEUE_DEPTH) n = QUEUE_DEPTH;
    return n;
  endfunction

  function automatic int ring_next(int idx);
    int n;
    n = idx + 1;
    if (n >= ring_len()) n = 0;
    return n;
  endfunction

  // Queue one entry; on overflow drop it and latch the fault
  function automatic bit ring_push(logic [8:0] entry);
    int n;
    n = ring_next(wr_idx);
    if (n == rd_idx) begin
      fault_mdl = 1'b1;
      return 1'b0;
    end
    wr_idx = n;
    ring_mem[n] = entry;
    return 1'b1;
  endfunction

  function automatic void timer_drop(int s);
    tmr_live[s] = 1'b0;
    for (int i = 0; i < TIMER_SLOTS; i++)
      if (tmr_live[i] && tmr_age[i] > tmr_age[s]) tmr_age[i]--;
  endfunction

  // Fire due timers, newest first
  function automatic void timers_fire(logic [31:0] now);
    int order [TIMER_SLOTS];
    int cnt;
    int s;
    cnt = 0;
    for (int a = 0; a < TIMER_SLOTS; a++)
      for (int i = 0; i < TIMER_SLOTS; i++)
        if (tmr_live[i] && tmr_age[i] == a) begin
          order[cnt] = i;
          cnt++;
        end
    for (int a = 0; a < cnt; a++) begin
      s = order[a];
      if (tmr_live[s] && (now - tmr_start[s]) >= tmr_ivl[s]) begin
        void'(ring_push({1'b0, tmr_task[s]}));
        if (tmr_rep[s]) tmr_start[s] = tmr_start[s] + tmr_ivl[s];
        else timer_drop(s);
      end
    end
  endfunction

  function automatic out_word_t sched_predict(in_word_t w);
    out_word_t r;
    logic [8:0] e;
    int i;
    r = '0;
    r.result_kind = K_REJECT;
    case (w.opcode)
      OP_STEP: begin
        if (rd_idx == wr_idx) timers_fire(w.now_ms);
        if (rd_idx == wr_idx) begin
          r.result_kind = K_IDLE;
        end else begin
          rd_idx = ring_next(rd_idx);
          e = ring_mem[rd_idx];
          if (e[8]) begin
            r.result_kind = K_STOP;
          end else begin
            r.result_kind = K_DISPATCH;
            r.task_out = e[7:0];
          end
        end
      end
      OP_POST: r.result_kind = ring_push({1'b0, w.task_id}) ? K_ACCEPT : K_REJECT;
      OP_STOP: r.result_kind = ring_push(9'h100) ? K_ACCEPT : K_REJECT;
      OP_ADD: begin
        for (i = 0; i < TIMER_SLOTS; i++)
          if (!tmr_live[i]) break;
        if (i < TIMER_SLOTS) begin
          for (int j = 0; j < TIMER_SLOTS; j++)
            if (tmr_live[j]) tmr_age[j]++;
          tmr_live[i]  = 1'b1;
          tmr_age[i]   = 0;
          tmr_start[i] = w.now_ms;
          tmr_ivl[i]   = w.interval;
          tmr_task[i]  = w.task_id;
          tmr_rep[i]   = w.periodic;
          r.result_kind = K_CREATED;
          r.slot_out    = 4'(i);
        end
      end
      OP_DEL: begin
        if (tmr_live[w.timer_slot]) begin
          timer_drop(int'(w.timer_slot));
          r.result_kind = K_ACCEPT;
        end
      end
      OP_DEL_ALL: begin
        for (int j = 0; j < TIMER_SLOTS; j++) tmr_live[j] = 1'b0;
        r.result_kind = K_ACCEPT;
      end
      default: ;
    endcase
    r.fault = fault_mdl;
    return r;
  endfunction

  task automatic send(logic [2:0] op, logic [31:0] now, logic [7:0] tid,
                      logic [31:0] ivl, bit per, logic [3:0] slot);
    in_word_t w;
    w.opcode     = op;
    w.now_ms     = now;
    w.task_id    = tid;
    w.interval   = ivl;
    w.periodic   = per;
    w.timer_slot = slot;
    cmd_q.push_back(w);
    owed_q.push_back(sched_predict(w));
  endtask

  // Random command: mostly coherent time base, some noise
  task automatic send_random();
    int pick;
    logic [31:0] now, ivl;
    logic [7:0]  tid;
    bit          per;
    logic [3:0]  slot;
    pick = $urandom_range(0, 99);
    tid  = 8'($urandom());
    per  = 1'($urandom());
    slot = 4'($urandom());
    if ($urandom_range(0, 19) == 0) now = $urandom();
    else now = sim_ms;
    case ($urandom_range(0, 9))
      0:       ivl = $urandom();
      1:       ivl = 32'd0;
      default: ivl = $urandom_range(0, 60);
    endcase
    if (pick < 40) begin
      sim_ms = sim_ms + $urandom_range(0, 20);
      send(OP_STEP, now, tid, $urandom(), per, slot);
    end else if (pick < 60) begin
      send(OP_POST, now, tid, $urandom(), per, slot);
    end else if (pick < 75) begin
      send(OP_ADD, now, tid, ivl, per, slot);
    end else if (pick < 85) begin
      send(OP_DEL, now, tid, ivl, per, slot);
    end else if (pick < 88) begin
      send(OP_DEL_ALL, now, tid, ivl, per, slot);
    end else if (pick < 95) begin
      send(OP_STOP, now, tid, ivl, per, slot);
    end else begin
      send($urandom_range(0, 1) ? OP_BAD6 : OP_BAD7, now, tid, ivl, per, slot);
    end
  endtask

  task automatic wait_quiet();
    wait (cmd_q.size() == 0 && owed_q.size() == 0 && !in_valid_i);
    repeat (30) @(posedge clk_i);
  endtask

  // Empty ring and timer table so a length change never exposes stale slots
  task automatic drain_ring();
    send(OP_DEL_ALL, sim_ms, 8'd0, 32'd0, 1'b0, 4'd0);
    while (rd_idx != wr_idx) send(OP_STEP, sim_ms, 8'd0, 32'd0, 1'b0, 4'd0);
  endtask

  task automatic set_len(logic [CFG_W-1:0] val);
    drain_ring();
    wait_quiet();
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    len_cfg = val;
  endtask

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Run limit
  initial begin
    #20ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Handshake bookkeeping and result check
  always @(posedge clk_i) begin
    in_fire  <= in_valid_i && in_ready_o;
    out_fire <= out_valid_o && out_ready_i;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (owed_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %h", out_data_o);
      end else begin
        if (out_data_o.result_kind !== owed_q[0].result_kind ||
            out_data_o.task_out !== owed_q[0].task_out ||
            out_data_o.slot_out !== owed_q[0].slot_out ||
            out_data_o.fault !== owed_q[0].fault) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch exp kind=%0d task=%0d slot=%0d fault=%0d",
                      " got kind=%0d task=%0d slot=%0d fault=%0d"},
                     owed_q[0].result_kind, owed_q[0].task_out, owed_q[0].slot_out,
                     owed_q[0].fault, out_data_o.result_kind, out_data_o.task_out,
                     out_data_o.slot_out, out_data_o.fault);
        end
        void'(owed_q.pop_front());
      end
    end
  end

  // Command driver
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_fire) begin
        drv_on = 1'b0;
        in_gap = idle_on ? $urandom_range(0, 15) : 0;
      end
      if (!drv_on && cmd_q.size() > 0) begin
        if (in_gap > 0) in_gap--;
        else begin
          in_data_i <= cmd_q.pop_front();
          drv_on = 1'b1;
        end
      end
      in_valid_i <= drv_on;
    end
  end

  // Result receiver with random back-pressure
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_fire) out_stall = idle_on ? $urandom_range(0, 15) : 0;
      if (out_stall > 0) begin
        out_stall--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Stimulus
  initial begin
    logic [CFG_W-1:0] lens [6];
    in_valid_i = 1'b0;
    in_data_i  = '0;
    out_ready_i = 1'b0;
    cfg_we_i   = 1'b0;
    cfg_data_i = '0;
    in_fire = 1'b0; out_fire = 1'b0; drv_on = 1'b0;
    in_gap = 0; out_stall = 0; mismatches = 0; idle_on = 1'b1;
    len_cfg = LEN_RESET; rd_idx = 0; wr_idx = 0; fault_mdl = 1'b0;
    sim_ms = 32'd0;
    for (int i = 0; i < TIMER_SLOTS; i++) tmr_live[i] = 1'b0;
    rst_ni = 1'b0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: posts, stop entry, timers at interval extremes, bad handles
    send(OP_POST, 32'd0, 8'd0, 32'd0, 1'b0, 4'd0);
    send(OP_POST, 32'd0, 8'hFF, 32'd0, 1'b0, 4'd0);
    send(OP_STOP, 32'd0, 8'd0, 32'd0, 1'b0, 4'd0);
    repeat (4) send(OP_STEP, 32'd0, 8'd0, 32'd0, 1'b0, 4'd0);
    send(OP_ADD, 32'd0, 8'hAA, 32'd0, 1'b0, 4'd0);
    send(OP_ADD, 32'd0, 8'h55, NEVER_MS, 1'b1, 4'd0);
    send(OP_ADD, 32'd0, 8'h11, 32'd5, 1'b1, 4'd0);
    repeat (2) send(OP_STEP, 32'd6, 8'd0, 32'd0, 1'b0, 4'd0);
    send(OP_STEP, NEVER_MS, 8'd0, 32'd0, 1'b0, 4'd0);
    send(OP_DEL, 32'd0, 8'd0, 32'd0, 1'b0, 4'd15);
    send(OP_DEL, 32'd0, 8'd0, 32'd0, 1'b0, 4'd1);
    send(OP_BAD6, 32'd0, 8'd0, 32'd0, 1'b0, 4'd0);
    send(OP_BAD7, NEVER_MS, 8'hFF, NEVER_MS, 1'b1, 4'hF);
    send(OP_DEL_ALL, 32'd0, 8'd0, 32'd0, 1'b0, 4'd0);
    // Full timer table rejects the extra add
    for (int i = 0; i <= TIMER_SLOTS; i++)
      send(OP_ADD, 32'd100, 8'(i), NEVER_MS, 1'b0, 4'd0);
    // Overflow on the shortest ring: task post and stop post both dropped
    set_len(7'd2);
    send(OP_POST, 32'd0, 8'd1, 32'd0, 1'b0, 4'd0);
    send(OP_POST, 32'd0, 8'd2, 32'd0, 1'b0, 4'd0);
    send(OP_STOP, 32'd0, 8'd0, 32'd0, 1'b0, 4'd0);

    // Random phases across ring lengths, including out-of-range settings
    lens[0] = 7'd2;  lens[1] = 7'd64; lens[2] = 7'd0;
    lens[3] = 7'd127; lens[4] = 7'd5; lens[5] = 7'd16;
    for (int p = 0; p < 6; p++) begin
      set_len(lens[p]);
      if (p == 3) sim_ms = 32'hFFFF_FF00;
      idle_on = (p != 2);
      repeat (150) send_random();
    end

    wait_quiet();
    if (mismatches == 0 && owed_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/trsts_pkg.sv
rtl/trsts_task_ring.sv
rtl/trsts_timer_cell.sv
rtl/task_ring_and_soft_timer_scheduler.sv
rtl/trsts_checker.sv
dv/tb_task_ring_and_soft_timer_scheduler.sv
